// ===== rtl/kss_pkg.sv =====
// ----------------------------------------------------------------------------
// kss_pkg: shared types and constants for the shared-store stack unit
// Sizes of the slot store, pointer types, command and status codes, and the
// write request that the control logic hands to the link store.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int SLOTS  = 16;
    localparam int STACKS = 4;
    localparam int DATA_W = 32;
    localparam int SID_W  = 2;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int PTR_W  = $clog2(SLOTS + 1);

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // The null pointer is the slot count itself.
    localparam ptr_t NIL = ptr_t'(SLOTS);

    localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'h7FFF_FFFF;

    typedef enum logic
    {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed
    {
        logic  en;
        addr_t addr;
        ptr_t  link;
    } link_wr_t;

    function automatic logic is_slot(ptr_t p);
        return p < NIL;
    endfunction

endpackage

// ===== rtl/k_stacks_shared_store_unit.sv =====
// ----------------------------------------------------------------------------
// k_stacks_shared_store_unit: several LIFO stacks in one shared slot store
// Free slots form a linked list headed by the free pointer; each stack is a
// linked chain from its top pointer. Push and pop relink one slot each.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Fields of one word
//  --------+-----------+---------------------+-----------------------------------
//  in      | into unit | in_valid, in_stall  | command, stack_id, push_value
//  out     | from unit | out_valid, out_stall| status, pop_value, store_full,
//          |           |                     | stack_empty
//
// Every operation runs in two steps: in the cycle a word is accepted the
// unit issues the reads of the link and data memories at the slot that the
// operation touches (the free head for a push, the stack top for a pop), and
// in the next cycle it takes the registered read data, writes the relinked
// slot back and loads the result register. The read data of the memories
// is registered, so a new word cannot enter until the current one is done.
// Reset is asynchronous and active low; it empties every stack and puts all
// slots on the free list, with no clearing pass, so a word may be accepted in
// the first cycle after reset. A new word may enter at the same edge at which
// the waiting result is taken; the input stalls only while an operation is
// in its execute state and while a waiting result is itself stalled.
//
module k_stacks_shared_store_unit (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic [kss_pkg::SID_W-1:0]    stack_id,
    input  logic signed [kss_pkg::DATA_W-1:0] push_value,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic signed [kss_pkg::DATA_W-1:0] pop_value,
    output logic                         store_full,
    output logic                         stack_empty
);

    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                      state_reg;

    // Operation held across its execute state.
    kss_pkg::cmd_t               cmd_reg;
    logic [kss_pkg::SID_W-1:0]   sid_reg;
    logic [kss_pkg::DATA_W-1:0]  val_reg;
    kss_pkg::ptr_t               slot_reg;
    logic                        hit_reg;
    logic                        sid_ok_reg;

    // Pointer state.
    kss_pkg::ptr_t               free_head_reg;
    kss_pkg::ptr_t               free_head_next;
    kss_pkg::ptr_t               stack_top_reg [kss_pkg::STACKS];
    kss_pkg::ptr_t               top_next;

    // Result register.
    logic                        out_valid_reg;
    kss_pkg::status_t            status_reg;
    kss_pkg::status_t            status_next;
    logic [kss_pkg::DATA_W-1:0]  pop_value_reg;
    logic [kss_pkg::DATA_W-1:0]  pop_value_next;
    logic                        store_full_reg;
    logic                        stack_empty_reg;

    logic                        in_fire;
    logic                        exec;
    logic                        sid_ok;
    kss_pkg::ptr_t               top_sel;
    kss_pkg::ptr_t               slot_sel;
    logic                        hit;
    kss_pkg::ptr_t               top_cur;
    kss_pkg::ptr_t               link_q;
    logic [kss_pkg::DATA_W-1:0]  data_q;
    kss_pkg::link_wr_t           link_wr;
    logic                        data_we;

    assign exec     = (state_reg == S_EXEC);
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;

    // The slot an accepted word touches: the free head for a push and the
    // addressed stack's top for a pop. The reads are issued at acceptance.
    assign sid_ok   = 32'(stack_id) < kss_pkg::STACKS;
    assign top_sel  = stack_top_reg[stack_id];
    assign slot_sel = (kss_pkg::cmd_t'(command) == kss_pkg::CMD_POP) ? top_sel
                                                                     : free_head_reg;
    assign hit      = sid_ok && kss_pkg::is_slot(slot_sel);

    kss_link_store u_links (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire && hit),
        .rd_addr (slot_sel[kss_pkg::ADDR_W-1:0]),
        .rd_link (link_q),
        .wr      (link_wr)
    );

    // Slot values are read only after a push has written them, so the data
    // RAM needs no valid bits.
    kss_ram #(
        .WIDTH (kss_pkg::DATA_W),
        .DEPTH (kss_pkg::SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (slot_reg[kss_pkg::ADDR_W-1:0]),
        .wdata (val_reg),
        .re    (in_fire && hit),
        .raddr (slot_sel[kss_pkg::ADDR_W-1:0]),
        .rdata (data_q)
    );

    assign top_cur = stack_top_reg[sid_reg];

    // Execute state: relink the slot and form the result. The pointer
    // registers and the memories are written at the same edge, so the next
    // word, accepted no earlier than the following cycle, sees them updated.
    always_comb
    begin
        free_head_next = free_head_reg;
        top_next       = top_cur;
        link_wr        = '0;
        data_we        = 1'b0;
        pop_value_next = '0;
        status_next    = kss_pkg::ST_OK;

        if (exec)
        begin
            unique case (cmd_reg)
                kss_pkg::CMD_PUSH:
                begin
                    if (hit_reg)
                    begin
                        free_head_next = link_q;
                        top_next       = slot_reg;
                        link_wr.en     = 1'b1;
                        link_wr.addr   = slot_reg[kss_pkg::ADDR_W-1:0];
                        link_wr.link   = top_cur;
                        data_we        = 1'b1;
                    end
                    else
                    begin
                        status_next = kss_pkg::ST_OVERFLOW;
                    end
                end
                kss_pkg::CMD_POP:
                begin
                    if (hit_reg)
                    begin
                        free_head_next = slot_reg;
                        top_next       = link_q;
                        link_wr.en     = 1'b1;
                        link_wr.addr   = slot_reg[kss_pkg::ADDR_W-1:0];
                        link_wr.link   = free_head_reg;
                        pop_value_next = data_q;
                    end
                    else
                    begin
                        status_next    = kss_pkg::ST_EMPTY;
                        pop_value_next = kss_pkg::EMPTY_VALUE;
                    end
                end
                default:
                begin
                    status_next = kss_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= kss_pkg::CMD_PUSH;
            sid_reg         <= '0;
            val_reg         <= '0;
            slot_reg        <= '0;
            hit_reg         <= 1'b0;
            sid_ok_reg      <= 1'b0;
            free_head_reg   <= '0;
            for (int i = 0; i < kss_pkg::STACKS; i++)
            begin
                stack_top_reg[i] <= kss_pkg::NIL;
            end
            out_valid_reg   <= 1'b0;
            status_reg      <= kss_pkg::ST_OK;
            pop_value_reg   <= '0;
            store_full_reg  <= 1'b0;
            stack_empty_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        cmd_reg    <= kss_pkg::cmd_t'(command);
                        sid_reg    <= stack_id;
                        val_reg    <= push_value;
                        slot_reg   <= slot_sel;
                        hit_reg    <= hit;
                        sid_ok_reg <= sid_ok;
                        state_reg  <= S_EXEC;
                    end
                    if (out_valid_reg && !out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_EXEC:
                begin
                    free_head_reg          <= free_head_next;
                    stack_top_reg[sid_reg] <= top_next;
                    out_valid_reg          <= 1'b1;
                    status_reg             <= status_next;
                    pop_value_reg          <= pop_value_next;
                    store_full_reg         <= !kss_pkg::is_slot(free_head_next);
                    stack_empty_reg        <= sid_ok_reg ? !kss_pkg::is_slot(top_next)
                                                         : 1'b1;
                    state_reg              <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign pop_value   = pop_value_reg;
    assign store_full  = store_full_reg;
    assign stack_empty = stack_empty_reg;

    // A result is only ever loaded into an empty result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec |-> !out_valid_reg)
        else $error("result register overwritten");

    // No word enters while an operation is in its execute state.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec |-> !in_fire)
        else $error("word accepted during an operation");

    // The free head is either a slot or null.
    assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= kss_pkg::NIL)
        else $error("free head out of range");

    // A successful pop frees a slot, so the store cannot be full after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec && hit_reg && cmd_reg == kss_pkg::CMD_POP) |=> !store_full_reg)
        else $error("store full after a successful pop");

    // A successful push leaves the addressed stack non-empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec && hit_reg && cmd_reg == kss_pkg::CMD_PUSH) |=> !stack_empty_reg)
        else $error("stack empty after a successful push");

endmodule

// ===== rtl/kss_ram.sv =====
// ----------------------------------------------------------------------------
// kss_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/kss_link_store.sv =====
// ----------------------------------------------------------------------------
// kss_link_store: next-pointer memory of the slot store
// Wraps the link RAM with one valid bit per entry, so that an entry never
// written reads as its reset value, the index of the following slot.
// ----------------------------------------------------------------------------
module kss_link_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  kss_pkg::addr_t    rd_addr,
    output kss_pkg::ptr_t     rd_link,
    input  kss_pkg::link_wr_t wr
);

    logic [kss_pkg::SLOTS-1:0] valid_reg;
    logic                      rd_valid_reg;
    kss_pkg::addr_t            rd_addr_reg;
    kss_pkg::ptr_t             ram_q;

    kss_ram #(
        .WIDTH (kss_pkg::PTR_W),
        .DEPTH (kss_pkg::SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.link),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_addr_reg  <= rd_addr;
            end
        end
    end

    // An unwritten entry links to the next slot; the last one links to null.
    assign rd_link = rd_valid_reg ? ram_q
                                  : kss_pkg::ptr_t'(rd_addr_reg) + kss_pkg::ptr_t'(1);

endmodule
